// ----- sv/mcpq_pkg.sv -----
// ----------------------------------------------------------------------------
// mcpq_pkg
// shared types and constants of the multi-channel pin qualifier
// ----------------------------------------------------------------------------
package mcpq_pkg;

    localparam int CHANNELS_DEF = 8;
    localparam int FIELD_W      = 8;
    localparam int IDX_CMP_W    = 6;
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;
    localparam int PROTECT_W    = 4;

    localparam logic [FIELD_W-1:0]   POLARITY_RESET = 8'd253;
    localparam logic [PROTECT_W-1:0] PROTECT_RESET  = 4'd2;

    localparam logic [PADDR_W-1:0] ADDR_POLARITY = 3'd0;
    localparam logic [PADDR_W-1:0] ADDR_PROTECT  = 3'd4;

    localparam logic [1:0] OP_POLL      = 2'd0;
    localparam logic [1:0] OP_REARM_ONE = 2'd1;
    localparam logic [1:0] OP_REARM_ALL = 2'd2;

    typedef enum logic [1:0] {
        CH_BEGIN   = 2'd0,
        CH_VALID   = 2'd1,
        CH_INVALID = 2'd2
    } ch_state_t;

    typedef struct packed {
        logic poll;
        logic rearm;
        logic match_first;
        logic match_confirm;
    } lane_ctrl_t;

    typedef struct packed {
        logic up;
        logic down;
        logic valid_next;
    } lane_res_t;

endpackage

// ----- sv/mcpq_lane.sv -----
// ----------------------------------------------------------------------------
// mcpq_lane
// one channel tracker: begin / valid / invalid state and its events
// ----------------------------------------------------------------------------
module mcpq_lane
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  mcpq_pkg::lane_ctrl_t  ctrl,
    output mcpq_pkg::lane_res_t   res
);

    mcpq_pkg::ch_state_t state_reg;
    mcpq_pkg::ch_state_t state_next;
    logic                both_match;

    assign both_match = ctrl.match_first && ctrl.match_confirm;

    always_comb
    begin
        state_next = state_reg;
        res.up     = 1'b0;
        res.down   = 1'b0;
        if (ctrl.rearm)
        begin
            state_next = mcpq_pkg::CH_BEGIN;
        end
        else if (ctrl.poll)
        begin
            unique case (state_reg)
                mcpq_pkg::CH_BEGIN:
                begin
                    if (both_match)
                    begin
                        state_next = mcpq_pkg::CH_VALID;
                        res.up     = 1'b1;
                    end
                    else
                    begin
                        state_next = mcpq_pkg::CH_INVALID;
                        res.down   = 1'b1;
                    end
                end
                mcpq_pkg::CH_VALID:
                begin
                    if (!ctrl.match_first)
                    begin
                        state_next = mcpq_pkg::CH_INVALID;
                        res.down   = 1'b1;
                    end
                end
                mcpq_pkg::CH_INVALID:
                begin
                    if (both_match)
                    begin
                        state_next = mcpq_pkg::CH_VALID;
                        res.up     = 1'b1;
                    end
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end
        res.valid_next = (state_next == mcpq_pkg::CH_VALID);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mcpq_pkg::CH_BEGIN;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- sv/mcpq_merge.sv -----
// ----------------------------------------------------------------------------
// mcpq_merge
// gathers the lane results into the result word and holds it for transfer
// ----------------------------------------------------------------------------
module mcpq_merge
#(
    parameter int CHANNELS = mcpq_pkg::CHANNELS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  mcpq_pkg::lane_res_t          lane_res [CHANNELS],
    input  logic                         skipped,
    input  logic                         result_stall,
    output logic                         result_valid,
    output logic [mcpq_pkg::FIELD_W-1:0] became_valid,
    output logic [mcpq_pkg::FIELD_W-1:0] became_invalid,
    output logic                         protect_skipped,
    output logic [mcpq_pkg::FIELD_W-1:0] valid_now
);

    logic [mcpq_pkg::FIELD_W-1:0] up_vec;
    logic [mcpq_pkg::FIELD_W-1:0] down_vec;
    logic [mcpq_pkg::FIELD_W-1:0] now_vec;
    logic                         valid_reg;
    logic                         valid_next;
    logic [mcpq_pkg::FIELD_W-1:0] up_reg;
    logic [mcpq_pkg::FIELD_W-1:0] down_reg;
    logic [mcpq_pkg::FIELD_W-1:0] now_reg;
    logic                         skip_reg;

    for (genvar j = 0; j < mcpq_pkg::FIELD_W; j++)
    begin : g_bit
        if (j < CHANNELS)
        begin : g_lane
            assign up_vec[j]   = lane_res[j].up;
            assign down_vec[j] = lane_res[j].down;
            assign now_vec[j]  = lane_res[j].valid_next;
        end
        else
        begin : g_none
            assign up_vec[j]   = 1'b0;
            assign down_vec[j] = 1'b0;
            assign now_vec[j]  = 1'b0;
        end
    end

    assign valid_next = accept || (valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            up_reg   <= up_vec;
            down_reg <= down_vec;
            now_reg  <= now_vec;
            skip_reg <= skipped;
        end
    end

    assign result_valid    = valid_reg;
    assign became_valid    = up_reg;
    assign became_invalid  = down_reg;
    assign protect_skipped = skip_reg;
    assign valid_now       = now_reg;

endmodule

// ----- sv/multi_channel_pin_qualifier.sv -----
// ----------------------------------------------------------------------------
// multi_channel_pin_qualifier
// debounced qualification of sense pins, one tracker lane per channel
// ----------------------------------------------------------------------------
// a result is presented from the output register in the cycle after its item transfer
// one item per cycle while item_stall is low; all lanes update together in that cycle
// the single output register stalls the item side only while a result is held
// reset: every channel in begin, polarity 253, first protect channel 2
// ----------------------------------------------------------------------------
module multi_channel_pin_qualifier
#(
    parameter int CHANNELS = mcpq_pkg::CHANNELS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mcpq_pkg::PADDR_W-1:0]   paddr,
    input  logic [mcpq_pkg::PDATA_W-1:0]   pwdata,
    output logic [mcpq_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    input  logic                           item_valid,
    output logic                           item_stall,
    input  logic [1:0]                     op,
    input  logic [mcpq_pkg::FIELD_W-1:0]   first_sample,
    input  logic [mcpq_pkg::FIELD_W-1:0]   confirm_sample,
    input  logic                           system_working,
    input  logic [2:0]                     channel,
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic [mcpq_pkg::FIELD_W-1:0]   became_valid,
    output logic [mcpq_pkg::FIELD_W-1:0]   became_invalid,
    output logic                           protect_skipped,
    output logic [mcpq_pkg::FIELD_W-1:0]   valid_now
);

    logic [mcpq_pkg::FIELD_W-1:0]   polarity_reg;
    logic [mcpq_pkg::PROTECT_W-1:0] protect_reg;
    logic                           cfg_write;
    logic                           accept;
    logic [CHANNELS-1:0]            protect_lane;
    logic                           skipped;
    mcpq_pkg::lane_ctrl_t           lane_ctrl [CHANNELS];
    mcpq_pkg::lane_res_t            lane_res  [CHANNELS];

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            polarity_reg <= mcpq_pkg::POLARITY_RESET;
            protect_reg  <= mcpq_pkg::PROTECT_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr == mcpq_pkg::ADDR_POLARITY)
            begin
                polarity_reg <= pwdata[mcpq_pkg::FIELD_W-1:0];
            end
            if (paddr == mcpq_pkg::ADDR_PROTECT)
            begin
                protect_reg <= pwdata[mcpq_pkg::PROTECT_W-1:0];
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == mcpq_pkg::ADDR_POLARITY)
        begin
            prdata = {{(mcpq_pkg::PDATA_W-mcpq_pkg::FIELD_W){1'b0}}, polarity_reg};
        end
        else if (paddr == mcpq_pkg::ADDR_PROTECT)
        begin
            prdata = {{(mcpq_pkg::PDATA_W-mcpq_pkg::PROTECT_W){1'b0}}, protect_reg};
        end
    end

    // item side
    assign item_stall = result_valid && result_stall;
    assign accept     = item_valid && !item_stall;
    assign skipped    = (op == mcpq_pkg::OP_POLL) && !system_working && (|protect_lane);

    for (genvar i = 0; i < CHANNELS; i++)
    begin : g_lane
        logic pin_first;
        logic pin_confirm;
        logic pol;

        assign protect_lane[i] = mcpq_pkg::IDX_CMP_W'(i)
                                 >= {{(mcpq_pkg::IDX_CMP_W-mcpq_pkg::PROTECT_W){1'b0}},
                                     protect_reg};

        if (i < mcpq_pkg::FIELD_W)
        begin : g_pin
            assign pin_first   = first_sample[i];
            assign pin_confirm = confirm_sample[i];
            assign pol         = polarity_reg[i];
        end
        else
        begin : g_nopin
            assign pin_first   = 1'b0;
            assign pin_confirm = 1'b0;
            assign pol         = 1'b0;
        end

        assign lane_ctrl[i].poll          = (op == mcpq_pkg::OP_POLL)
                                            && (system_working || !protect_lane[i]);
        assign lane_ctrl[i].rearm         = ((op == mcpq_pkg::OP_REARM_ONE)
                                             && (mcpq_pkg::IDX_CMP_W'(i)
                                                 == {{(mcpq_pkg::IDX_CMP_W-3){1'b0}}, channel}))
                                            || ((op == mcpq_pkg::OP_REARM_ALL)
                                                && protect_lane[i]);
        assign lane_ctrl[i].match_first   = (pin_first == pol);
        assign lane_ctrl[i].match_confirm = (pin_confirm == pol);

        mcpq_lane u_lane
        (
            .clk    (clk),
            .rst_n  (rst_n),
            .accept (accept),
            .ctrl   (lane_ctrl[i]),
            .res    (lane_res[i])
        );
    end

    mcpq_merge
    #(
        .CHANNELS (CHANNELS)
    )
    u_merge
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .lane_res        (lane_res),
        .skipped         (skipped),
        .result_stall    (result_stall),
        .result_valid    (result_valid),
        .became_valid    (became_valid),
        .became_invalid  (became_invalid),
        .protect_skipped (protect_skipped),
        .valid_now       (valid_now)
    );

    // checks
    a_events_exclusive : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((became_valid & became_invalid) == '0))
        else $error("channel raised both events");

    a_up_is_valid : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((became_valid & ~valid_now) == '0))
        else $error("valid event on channel not valid");

    a_down_not_valid : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((became_invalid & valid_now) == '0))
        else $error("invalid event on channel still valid");

    a_stall_only_when_held : assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid)
        else $error("item side stalled with no result held");

endmodule
